### rtl/core/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared constants, opcodes and controller/datapath interface types for the
// rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    // default operand width and fixed result field width
    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int RES_WIDTH         = 33;

    // operation codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // divider operand select
    localparam logic DIV_SEL_NUM = 1'b0;
    localparam logic DIV_SEL_DEN = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       mul;
        logic [1:0] mstep;
        logic       gcd_init;
        logic       gcd_step;
        logic       g_latch;
        logic       div_init;
        logic       div_sel;
        logic       div_step;
        logic       store_num;
        logic       emit;
    } rau_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic gcd_done;
        logic g_zero;
        logic out_busy;
    } rau_status_t;

endpackage

### rtl/core/rau_ctrl.sv
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer: operand load, multiply steps, gcd loop, two divisions, output.
// ----------------------------------------------------------------------------
module rau_ctrl #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rau_pkg::rau_status_t status,
    output rau_pkg::rau_cmd_t    cmd
);

    localparam int MW = 2 * OPERAND_WIDTH + 1;
    localparam int CW = $clog2(MW);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_GINIT,
        S_GCD,
        S_DIVN,
        S_STORE,
        S_DIVD,
        S_OUT
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          last_div;

    assign last_div = (cnt_reg == CW'(MW - 1));
    assign in_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul   = 1'b1;
                cmd.mstep = cnt_reg[1:0];
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg[1:0] == 2'd3)
                begin
                    state_next = S_GINIT;
                end
            end
            S_GINIT:
            begin
                cmd.gcd_init = 1'b1;
                state_next   = S_GCD;
            end
            S_GCD:
            begin
                if (status.gcd_done)
                begin
                    cmd.g_latch = 1'b1;
                    cmd.div_init = 1'b1;
                    cmd.div_sel  = rau_pkg::DIV_SEL_NUM;
                    cnt_next     = '0;
                    state_next   = status.g_zero ? S_OUT : S_DIVN;
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                end
            end
            S_DIVN:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (last_div)
                begin
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                cmd.store_num = 1'b1;
                cmd.div_init  = 1'b1;
                cmd.div_sel   = rau_pkg::DIV_SEL_DEN;
                cnt_next      = '0;
                state_next    = S_DIVD;
            end
            S_DIVD:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (last_div)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

### rtl/core/rau_dp.sv
// ----------------------------------------------------------------------------
// rau_dp
// Datapath: shared multiplier, binary gcd, restoring divider, output register.
// ----------------------------------------------------------------------------
module rau_dp #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rau_pkg::rau_cmd_t                   cmd,
    output rau_pkg::rau_status_t                status,
    input  logic [1:0]                          in_opcode,
    input  logic signed [OPERAND_WIDTH-1:0]     in_a_num,
    input  logic signed [OPERAND_WIDTH-1:0]     in_a_den,
    input  logic signed [OPERAND_WIDTH-1:0]     in_b_num,
    input  logic signed [OPERAND_WIDTH-1:0]     in_b_den,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [rau_pkg::RES_WIDTH-1:0] out_num,
    output logic signed [rau_pkg::RES_WIDTH-1:0] out_den,
    output logic                                out_zero
);

    localparam int W  = OPERAND_WIDTH;
    localparam int MW = 2 * W + 1;
    localparam int KW = $clog2(MW + 1);
    localparam int RW = rau_pkg::RES_WIDTH;

    // magnitude of a raw value
    function automatic logic [MW-1:0] mag(input logic signed [MW-1:0] v);
        return v[MW-1] ? MW'(-v) : MW'(v);
    endfunction

    // wrap or extend to the result field
    function automatic logic signed [RW-1:0] to_res(input logic signed [MW-1:0] v);
        logic signed [63:0] t;
        t = 64'(v);
        return t[RW-1:0];
    endfunction

    logic [1:0]               op_reg;
    logic signed [W-1:0]      an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [W-1:0]      mul_a, mul_b;
    logic signed [2*W-1:0]    prod_reg;
    logic signed [MW-1:0]     num_reg, den_reg;
    logic [MW-1:0]            ga_reg, gb_reg, g_reg;
    logic [KW-1:0]            k_reg;
    logic [MW:0]              gdiff;
    logic [MW-1:0]            dq_reg;
    logic [MW:0]              rem_reg;
    logic [MW:0]              trial;
    logic [MW:0]              trial_sub;
    logic                     qbit;
    logic signed [MW-1:0]     rnum_reg;
    logic signed [MW-1:0]     qden;
    logic signed [RW-1:0]     out_num_reg, out_den_reg;
    logic                     out_zero_reg, out_valid_reg;

    // multiplier operand select per step
    always_comb
    begin
        case (cmd.mstep)
            2'd0:
            begin
                mul_a = an_reg;
                mul_b = (op_reg == rau_pkg::OP_MUL) ? bn_reg : bd_reg;
            end
            2'd1:
            begin
                mul_a = (op_reg == rau_pkg::OP_MUL) ? ad_reg : bn_reg;
                mul_b = (op_reg == rau_pkg::OP_MUL) ? bd_reg : ad_reg;
            end
            default:
            begin
                mul_a = ad_reg;
                mul_b = bd_reg;
            end
        endcase
    end

    // gcd and divider step logic
    assign gdiff     = {1'b0, ga_reg} - {1'b0, gb_reg};
    assign trial     = {rem_reg[MW-1:0], dq_reg[MW-1]};
    assign trial_sub = trial - {1'b0, g_reg};
    assign qbit      = !trial_sub[MW];
    assign qden      = den_reg[MW-1] ? -$signed(dq_reg) : $signed(dq_reg);

    assign status.gcd_done = (ga_reg == '0) || (gb_reg == '0);
    assign status.g_zero   = ((ga_reg | gb_reg) == '0);
    assign status.out_busy = out_valid_reg && !out_ready;

    // operand, product and raw fraction registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= in_opcode;
            an_reg <= in_a_num;
            ad_reg <= in_a_den;
            bn_reg <= in_b_num;
            bd_reg <= in_b_den;
        end
        if (cmd.mul)
        begin
            prod_reg <= mul_a * mul_b;
            case (cmd.mstep)
                2'd1:
                begin
                    num_reg <= MW'(prod_reg);
                end
                2'd2:
                begin
                    case (op_reg)
                        rau_pkg::OP_ADD: num_reg <= num_reg + MW'(prod_reg);
                        rau_pkg::OP_SUB: num_reg <= num_reg - MW'(prod_reg);
                        default:         den_reg <= MW'(prod_reg);
                    endcase
                end
                2'd3:
                begin
                    if (op_reg == rau_pkg::OP_ADD || op_reg == rau_pkg::OP_SUB)
                    begin
                        den_reg <= MW'(prod_reg);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // binary gcd of the magnitudes
    always_ff @(posedge clk)
    begin
        if (cmd.gcd_init)
        begin
            ga_reg <= mag(den_reg);
            gb_reg <= mag(num_reg);
            k_reg  <= '0;
        end
        else if (cmd.gcd_step)
        begin
            if (!ga_reg[0] && !gb_reg[0])
            begin
                ga_reg <= ga_reg >> 1;
                gb_reg <= gb_reg >> 1;
                k_reg  <= k_reg + 1'b1;
            end
            else if (!ga_reg[0])
            begin
                ga_reg <= ga_reg >> 1;
            end
            else if (!gb_reg[0])
            begin
                gb_reg <= gb_reg >> 1;
            end
            else if (!gdiff[MW])
            begin
                ga_reg <= gdiff[MW:1];
            end
            else
            begin
                gb_reg <= MW'((gb_reg - ga_reg) >> 1);
            end
        end
        if (cmd.g_latch)
        begin
            g_reg <= (ga_reg | gb_reg) << k_reg;
        end
    end

    // restoring divider, quotient shifts into the dividend register
    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            dq_reg  <= (cmd.div_sel == rau_pkg::DIV_SEL_DEN) ? mag(den_reg) : mag(num_reg);
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dq_reg  <= {dq_reg[MW-2:0], qbit};
            rem_reg <= qbit ? trial_sub : trial;
        end
        if (cmd.store_num)
        begin
            rnum_reg <= num_reg[MW-1] ? -$signed(dq_reg) : $signed(dq_reg);
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if (g_reg == '0)
            begin
                out_num_reg  <= '0;
                out_den_reg  <= '0;
                out_zero_reg <= 1'b1;
            end
            else
            begin
                out_num_reg  <= to_res(rnum_reg);
                out_den_reg  <= to_res(qden);
                out_zero_reg <= 1'b0;
            end
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_num   = out_num_reg;
    assign out_den   = out_den_reg;
    assign out_zero  = out_zero_reg;

endmodule

### rtl/core/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Add, subtract, multiply or divide two signed fractions and reduce by gcd.
// ----------------------------------------------------------------------------
// Input beat on s_axis: opcode and the fractions A = a_num/a_den and
// B = b_num/b_den. Output beat on m_axis: reduced res_num/res_den, with
// tuser set when the raw result was 0/0 (data then 0/0). The denominator
// keeps the sign it was computed with.
// One item is worked at a time; s_axis_tready is high only while idle.
// Per item: operand load, the multiply steps on the shared multiplier, gcd
// setup, the binary gcd steps and taking the gcd, then two restoring
// divisions with a store of the numerator between them, then output. A 0/0
// result skips the divisions.
// The output register holds a finished beat while m_axis_tready is low;
// the next input is accepted meanwhile and the block waits at the end of
// its work until the register is free. Reset clears the sequencer and the
// output valid; no result is pending after reset.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // opcode, a_num, a_den, b_num, b_den from bit 0 up, zero padded
    input  logic [((4*OPERAND_WIDTH+2+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // res_num, res_den from bit 0 up, zero padded
    output logic [71:0] m_axis_tdata,
    // zero_over_zero
    output logic m_axis_tuser
);

    localparam int W  = OPERAND_WIDTH;
    localparam int RW = rau_pkg::RES_WIDTH;

    rau_pkg::rau_cmd_t    cmd;
    rau_pkg::rau_status_t status;
    logic signed [RW-1:0] res_num, res_den;

    // sequencer
    rau_ctrl #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic
    rau_dp #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_opcode (s_axis_tdata[1:0]),
        .in_a_num  (s_axis_tdata[2+W-1:2]),
        .in_a_den  (s_axis_tdata[2+2*W-1:2+W]),
        .in_b_num  (s_axis_tdata[2+3*W-1:2+2*W]),
        .in_b_den  (s_axis_tdata[2+4*W-1:2+3*W]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_num   (res_num),
        .out_den   (res_den),
        .out_zero  (m_axis_tuser)
    );

    assign m_axis_tdata = {6'd0, res_den, res_num};

endmodule

### rtl/core/rau_checker.sv
// ----------------------------------------------------------------------------
// rau_checker
// Port-level checks for the rational arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module rau_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // output beat holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat dropped or changed while stalled");

    // one item at a time: busy right after an accepted beat
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while busy");

    // a 0/0 beat carries zero data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 72'd0)
        else $error("0/0 flag with nonzero data");

    // a reduced fraction is never 0/0 and padding stays clear
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            m_axis_tdata[65:0] != 66'd0 && m_axis_tdata[71:66] == 6'd0)
        else $error("reduced result malformed");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
